// ===== rtl/core/scfr_pkg.sv =====
// Shared types and constants of the sync checksum frame receiver.
package scfr_pkg;

    localparam int BYTE_W       = 8;
    localparam int INDEX_W      = 6;
    localparam int COUNT_W      = 16;
    localparam int LIMIT_W      = 8;
    localparam int PERIOD_W     = 7;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 48;

    localparam logic [BYTE_W-1:0]     SYNC0             = 8'hEB;
    localparam logic [BYTE_W-1:0]     SYNC1             = 8'h90;
    localparam logic [LIMIT_W-1:0]    FAIL_LIMIT_RESET  = 8'd5;
    localparam logic [PERIOD_W-1:0]   RATE_PERIOD_RESET = 7'd10;

    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_FAIL_LIMIT  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_PERIOD = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT,
        ST_STATUS
    } scfr_state_t;

    typedef struct packed {
        logic wr_byte;
        logic tick;
        logic drop;
        logic frame_good;
        logic emit;
        logic status;
    } scfr_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic window_good;
        logic emit_last;
        logic out_free;
    } scfr_stat_t;

endpackage

// ===== rtl/core/scfr_ctrl.sv =====
// Controller state machine of the sync checksum frame receiver.
module scfr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  scfr_pkg::scfr_stat_t stat,
    output scfr_pkg::scfr_cmd_t  cmd
);
    import scfr_pkg::*;

    scfr_state_t state_reg;
    scfr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == OP_TICK) begin
                        cmd.tick   = 1'b1;
                        state_next = ST_STATUS;
                    end else begin
                        cmd.wr_byte = 1'b1;
                        if (stat.fill_last) begin
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK: begin
                if (stat.window_good) begin
                    cmd.frame_good = 1'b1;
                    state_next     = ST_EMIT;
                end else begin
                    cmd.drop   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_STATUS: begin
                if (stat.out_free) begin
                    cmd.status = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/scfr_datapath.sv =====
// Datapath: window ring memory, running sum, link monitor and output register.
module scfr_datapath #(
    parameter int FRAME_LEN = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [scfr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [scfr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [scfr_pkg::BYTE_W-1:0]         rx_byte,
    input  scfr_pkg::scfr_cmd_t                 cmd,
    output scfr_pkg::scfr_stat_t                stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [scfr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import scfr_pkg::*;

    localparam int IDX_W  = $clog2(FRAME_LEN);
    localparam int FILL_W = $clog2(FRAME_LEN + 1);

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (IDX_W+1)'(FRAME_LEN)) begin
            s = s - (IDX_W+1)'(FRAME_LEN);
        end
        return s[IDX_W-1:0];
    endfunction

    logic [BYTE_W-1:0]   window_mem [FRAME_LEN];

    logic [LIMIT_W-1:0]  fail_limit_reg;
    logic [PERIOD_W-1:0] rate_period_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [BYTE_W-1:0]   sum_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [COUNT_W-1:0]  frame_cnt_reg;
    logic [COUNT_W-1:0]  snapshot_reg;
    logic [COUNT_W-1:0]  rate_reg;
    logic [LIMIT_W-1:0]  silence_reg;
    logic                fail_reg;
    logic [PERIOD_W-1:0] phase_reg;
    logic                out_valid_reg;

    logic [BYTE_W-1:0]   first_reg;
    logic [BYTE_W-1:0]   second_reg;
    logic                out_kind_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic [INDEX_W-1:0]  out_idx_reg;
    logic                out_last_reg;
    logic                out_fail_reg;
    logic [COUNT_W-1:0]  out_rate_reg;
    logic [COUNT_W-1:0]  out_total_reg;

    logic [IDX_W-1:0]    waddr;
    logic [IDX_W-1:0]    raddr;
    logic [LIMIT_W-1:0]  silence_inc;
    logic [PERIOD_W-1:0] phase_inc;

    assign waddr       = ring_add(head_reg, fill_reg[IDX_W-1:0]);
    assign raddr       = cmd.emit ? ring_add(head_reg, idx_reg)
                                  : ring_add(head_reg, IDX_W'(2));
    assign silence_inc = (silence_reg == '1) ? silence_reg : silence_reg + 1'b1;
    assign phase_inc   = phase_reg + 1'b1;

    assign stat.fill_last   = (fill_reg == FILL_W'(FRAME_LEN - 1));
    assign stat.window_good = (first_reg == SYNC0) && (second_reg == SYNC1)
                              && (sum_reg == '0);
    assign stat.emit_last   = (idx_reg == IDX_W'(FRAME_LEN - 1));
    assign stat.out_free    = !out_valid_reg || m_tready;

    // Control state and monitor counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_limit_reg  <= FAIL_LIMIT_RESET;
            rate_period_reg <= RATE_PERIOD_RESET;
            head_reg        <= '0;
            fill_reg        <= '0;
            sum_reg         <= '0;
            idx_reg         <= '0;
            frame_cnt_reg   <= '0;
            snapshot_reg    <= '0;
            rate_reg        <= '0;
            silence_reg     <= '0;
            fail_reg        <= 1'b0;
            phase_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_FAIL_LIMIT:  fail_limit_reg  <= cfg_wdata;
                    REG_RATE_PERIOD: rate_period_reg <= cfg_wdata[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.wr_byte) begin
                fill_reg <= fill_reg + 1'b1;
                sum_reg  <= sum_reg + rx_byte;
            end
            if (cmd.drop) begin
                head_reg <= ring_add(head_reg, IDX_W'(1));
                fill_reg <= fill_reg - 1'b1;
                sum_reg  <= sum_reg - first_reg;
            end
            if (cmd.frame_good) begin
                fill_reg      <= '0;
                sum_reg       <= '0;
                idx_reg       <= '0;
                frame_cnt_reg <= frame_cnt_reg + 1'b1;
                silence_reg   <= '0;
                fail_reg      <= 1'b0;
            end
            if (cmd.emit) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.tick) begin
                silence_reg <= silence_inc;
                if (silence_inc >= fail_limit_reg) begin
                    fail_reg <= 1'b1;
                end
                if (phase_inc >= rate_period_reg) begin
                    phase_reg    <= '0;
                    rate_reg     <= frame_cnt_reg - snapshot_reg;
                    snapshot_reg <= frame_cnt_reg;
                end else begin
                    phase_reg <= phase_inc;
                end
            end
            if (cmd.emit || cmd.status) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Window memory, header bytes and result payload.
    always_ff @(posedge aclk) begin
        if (cmd.wr_byte) begin
            window_mem[waddr] <= rx_byte;
            if (fill_reg == FILL_W'(0)) begin
                first_reg <= rx_byte;
            end
            if (fill_reg == FILL_W'(1)) begin
                second_reg <= rx_byte;
            end
        end
        if (cmd.drop) begin
            first_reg  <= second_reg;
            second_reg <= window_mem[raddr];
        end
        if (cmd.emit) begin
            out_kind_reg  <= KIND_FRAME;
            out_byte_reg  <= window_mem[raddr];
            out_idx_reg   <= INDEX_W'(idx_reg);
            out_last_reg  <= stat.emit_last;
            out_fail_reg  <= 1'b0;
            out_rate_reg  <= '0;
            out_total_reg <= '0;
        end
        if (cmd.status) begin
            out_kind_reg  <= KIND_STATUS;
            out_byte_reg  <= '0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_fail_reg  <= fail_reg;
            out_rate_reg  <= rate_reg;
            out_total_reg <= frame_cnt_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_total_reg, out_rate_reg, out_fail_reg,
                       out_idx_reg, out_byte_reg};

endmodule

// ===== rtl/core/sync_checksum_frame_receiver.sv =====
// A byte request is taken in the idle state; when it fills the window, the check
// state follows, then FRAME_LEN frame bytes leave one per cycle from the ring memory
// port while the result register is free. A full window that fails the check drops
// its oldest byte in the check state. A tick request gives its status result once
// the register is free. One request at a time; a good frame holds input while streaming.
// Reset (aresetn low, synchronous) clears counters, flags and window fill; no clear pass.
module sync_checksum_frame_receiver #(
    parameter int FRAME_LEN = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [scfr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [scfr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [scfr_pkg::S_TDATA_W-1:0]      s_tdata,  // [7:0] rx_byte
    input  logic                                s_tuser,  // [0] opcode
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] frame_byte, [13:8] byte_index, [14] link_fail,
    // [30:15] frame_rate, [46:31] frames_total, [47] zero
    output logic [scfr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,  // [0] kind
    output logic                                m_tlast   // last_of_frame
);
    import scfr_pkg::*;

    scfr_cmd_t  cmd;
    scfr_stat_t stat;

    // Sequence each request: take bytes into the window, check a full window, then either
    // stream the frame out or drop the oldest byte; answer a tick with a status result.
    scfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the ring window with its running sum and header bytes, the link
    // monitor counters, and the result register that parts the two channels.
    scfr_datapath #(
        .FRAME_LEN (FRAME_LEN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (s_tdata[BYTE_W-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
